@@ rtl/core/uartrf_pkg.sv @@
package uartrf_pkg;

   // Field widths of the request and response words.
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 4;
   localparam int DATA_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int SPACE_W = 7;

   // Receive FIFO depth used when the top level is not told otherwise.
   localparam int DEF_FIFO_DEPTH = 64;

   // Register map, word indexes.
   localparam int REG_COUNT = 12;
   localparam logic [IDX_W-1:0] R_CON    = 4'd1;
   localparam logic [IDX_W-1:0] R_FCON   = 4'd2;
   localparam logic [IDX_W-1:0] R_TRSTAT = 4'd4;
   localparam logic [IDX_W-1:0] R_ERSTAT = 4'd5;
   localparam logic [IDX_W-1:0] R_FSTAT  = 4'd6;
   localparam logic [IDX_W-1:0] R_TXH    = 4'd8;
   localparam logic [IDX_W-1:0] R_RXH    = 4'd9;

   // Register bit fields.
   localparam logic [DATA_W-1:0] TRSTAT_RESET = 32'h0000_0006;
   localparam logic [DATA_W-1:0] ST_RX_READY  = 32'h0000_0001;
   localparam logic [DATA_W-1:0] ST_TX_EMPTY  = 32'h0000_0006;
   localparam logic [DATA_W-1:0] FS_FULL_BIT  = 32'h0000_0040;
   localparam int                FS_COUNT_W   = 6;
   localparam logic [1:0]        CON_MODE_ON  = 2'b01;

   // Request command codes; code 3 is unused.
   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RECV  = 2'd2
   } cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request word and start the FIFO head read
      logic execute;   // update the register state and load the response
   } ctrl_cmd_type;

endpackage

@@ rtl/core/uartrf_if.sv @@
interface uartrf_req_if;
   import uartrf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [IDX_W-1:0]  register_index;
   logic [DATA_W-1:0] write_data;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, command, register_index, write_data, rx_byte,
                   input ready);
   modport sink   (input valid, command, register_index, write_data, rx_byte,
                   output ready);
endinterface

interface uartrf_rsp_if;
   import uartrf_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  read_data;
   logic               tx_valid;
   logic [BYTE_W-1:0]  tx_byte;
   logic               rx_irq;
   logic               tx_irq;
   logic [SPACE_W-1:0] rx_space;

   modport source (output valid, read_data, tx_valid, tx_byte, rx_irq, tx_irq, rx_space,
                   input ready);
   modport sink   (input valid, read_data, tx_valid, tx_byte, rx_irq, tx_irq, rx_space,
                   output ready);
endinterface

interface uartrf_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/uart_register_file_rx_fifo_core.sv @@
// UART register side with a receive FIFO. Every request word is a bus read,
// a bus write or a byte arriving from the serial line, and each one produces
// exactly one response word. On acceptance the word is latched and the FIFO
// head entry is read from the receive memory, whose read data is registered;
// then, in the execute state, the register state is updated and the response
// register is loaded. A new request is taken in the same cycle that the
// pending response is taken, so no new word enters before the last response
// has been taken; the execute state exists for the registered read port of
// the receive FIFO memory. The link_present setting is written through the
// csr channel, which is always ready; the user must write it only while no
// request is in flight, as the block does not enforce this. The receive
// memory needs no clearing pass, as its head data is used only once filled.
module uart_register_file_rx_fifo_core #(
   parameter int FIFO_DEPTH = uartrf_pkg::DEF_FIFO_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   uartrf_req_if.sink   req_if,
   uartrf_rsp_if.source rsp_if,
   uartrf_csr_if.sink   csr_if
);
   import uartrf_pkg::*;

   ctrl_cmd_type cmd;

   // The setting register can be written in any cycle.
   assign csr_if.ready = 1'b1;

   // The controller sequences each word: capture, execute, then hold the
   // response until the sink takes it.
   uartrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // The datapath holds the register file, the FIFO pointers, the receive
   // memory and the response register.
   uartrf_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_write          (csr_if.valid && csr_if.ready),
      .csr_data           (csr_if.data),
      .req_command        (req_if.command),
      .req_register_index (req_if.register_index),
      .req_write_data     (req_if.write_data),
      .req_rx_byte        (req_if.rx_byte),
      .rsp_read_data      (rsp_if.read_data),
      .rsp_tx_valid       (rsp_if.tx_valid),
      .rsp_tx_byte        (rsp_if.tx_byte),
      .rsp_rx_irq         (rsp_if.rx_irq),
      .rsp_tx_irq         (rsp_if.tx_irq),
      .rsp_rx_space       (rsp_if.rx_space)
   );

endmodule

@@ rtl/core/uartrf_ram.sv @@
module uartrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/uartrf_ctrl.sv @@
module uartrf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output uartrf_pkg::ctrl_cmd_type  cmd
);
   import uartrf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // A new word may enter as soon as the pending response leaves.
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready);
   assign accept    = req_valid && req_ready;

   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_valid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= accept ? ST_EXEC : ST_IDLE;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/uartrf_dp.sv @@
module uartrf_dp #(
   parameter int FIFO_DEPTH = uartrf_pkg::DEF_FIFO_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  uartrf_pkg::ctrl_cmd_type           cmd,
   input  logic                               csr_write,
   input  logic                               csr_data,
   input  logic [uartrf_pkg::CMD_W-1:0]       req_command,
   input  logic [uartrf_pkg::IDX_W-1:0]       req_register_index,
   input  logic [uartrf_pkg::DATA_W-1:0]      req_write_data,
   input  logic [uartrf_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic [uartrf_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                               rsp_tx_valid,
   output logic [uartrf_pkg::BYTE_W-1:0]      rsp_tx_byte,
   output logic                               rsp_rx_irq,
   output logic                               rsp_tx_irq,
   output logic [uartrf_pkg::SPACE_W-1:0]     rsp_rx_space
);
   import uartrf_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // Latched request word.
   logic [CMD_W-1:0]  command_ff;
   logic [IDX_W-1:0]  index_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [BYTE_W-1:0] rbyte_ff;

   // Architectural state.
   logic [DATA_W-1:0] rf_ff [REG_COUNT];
   logic [DATA_W-1:0] rf_in [REG_COUNT];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rx_on_ff, rx_on_in;
   logic              tx_on_ff, tx_on_in;
   logic              fifo_on_ff, fifo_on_in;
   logic              link_ff;

   // Response register.
   logic [DATA_W-1:0]  rd_ff, rd_in;
   logic               txv_ff, txv_in;
   logic [BYTE_W-1:0]  txb_ff, txb_in;
   logic               rirq_ff, rirq_in;
   logic               tirq_ff, tirq_in;
   logic [SPACE_W-1:0] space_ff, space_in;

   logic              ram_we;
   logic [BYTE_W-1:0] ram_rdata;

   // The head entry is read when the word is captured, so it is ready
   // by the time a pop executes.
   uartrf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_rx_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (rbyte_ff),
      .rd_en   (cmd.capture),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rf_in      = rf_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      rx_on_in   = rx_on_ff;
      tx_on_in   = tx_on_ff;
      fifo_on_in = fifo_on_ff;
      rd_in      = '0;
      txv_in     = 1'b0;
      txb_in     = '0;
      rirq_in    = 1'b0;
      tirq_in    = 1'b0;
      ram_we     = 1'b0;

      case (command_ff)
         CMD_READ: begin
            if (index_ff < IDX_W'(REG_COUNT)) begin
               if (index_ff == R_ERSTAT) begin
                  rd_in           = rf_ff[index_ff];
                  rf_in[R_ERSTAT] = '0;
               end else if (index_ff == R_RXH) begin
                  if (!fifo_on_ff) begin
                     rf_in[R_TRSTAT] = rf_ff[R_TRSTAT] & ~ST_RX_READY;
                     rd_in           = rf_ff[R_RXH];
                  end else if (count_ff != '0) begin
                     rd_in    = DATA_W'(ram_rdata);
                     head_in  = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                     if (count_in == '0) begin
                        rf_in[R_TRSTAT] = rf_ff[R_TRSTAT] & ~ST_RX_READY;
                     end else begin
                        rf_in[R_TRSTAT] = rf_ff[R_TRSTAT] | ST_RX_READY;
                     end
                     rf_in[R_FSTAT] = rf_ff[R_FSTAT] & ~FS_FULL_BIT;
                     rf_in[R_FSTAT][FS_COUNT_W-1:0] = FS_COUNT_W'(count_in);
                  end
               end else begin
                  rd_in = rf_ff[index_ff];
               end
            end
         end
         CMD_WRITE: begin
            if (index_ff < IDX_W'(REG_COUNT)) begin
               if (index_ff == R_CON) begin
                  rf_in[R_CON] = wdata_ff;
                  rx_on_in     = (wdata_ff[1:0] == CON_MODE_ON);
                  tx_on_in     = (wdata_ff[3:2] == CON_MODE_ON);
                  tirq_in      = tx_on_in;
               end else if (index_ff == R_FCON) begin
                  rf_in[R_FCON] = wdata_ff;
                  fifo_on_in    = wdata_ff[0];
               end else if (index_ff == R_TXH) begin
                  // The transmit register is never stored.
                  if (link_ff) begin
                     rf_in[R_TRSTAT] = rf_ff[R_TRSTAT] | ST_TX_EMPTY;
                     txv_in          = 1'b1;
                     txb_in          = wdata_ff[BYTE_W-1:0];
                     tirq_in         = tx_on_ff;
                  end
               end else begin
                  rf_in[index_ff] = wdata_ff;
               end
            end
         end
         CMD_RECV: begin
            if (rx_on_ff) begin
               if (fifo_on_ff) begin
                  if (count_ff < CNT_W'(FIFO_DEPTH)) begin
                     ram_we   = cmd.execute;
                     tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     rirq_in  = 1'b1;
                     if (count_in == CNT_W'(FIFO_DEPTH)) begin
                        rf_in[R_FSTAT] = rf_ff[R_FSTAT] | FS_FULL_BIT;
                     end
                     rf_in[R_FSTAT][FS_COUNT_W-1:0] = FS_COUNT_W'(count_in);
                     rf_in[R_TRSTAT] = rf_ff[R_TRSTAT] | ST_RX_READY;
                  end
               end else begin
                  rf_in[R_RXH]    = DATA_W'(rbyte_ff);
                  rirq_in         = 1'b1;
                  rf_in[R_TRSTAT] = rf_ff[R_TRSTAT] | ST_RX_READY;
               end
            end
         end
         default: begin
            // Unused command: no state change, only the space figure.
         end
      endcase

      space_in = fifo_on_in ? (SPACE_W'(FIFO_DEPTH) - SPACE_W'(count_in)) : SPACE_W'(1);
   end

   // Request word and response fields: payload only.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         index_ff   <= req_register_index;
         wdata_ff   <= req_write_data;
         rbyte_ff   <= req_rx_byte;
      end
      if (cmd.execute) begin
         rd_ff    <= rd_in;
         txv_ff   <= txv_in;
         txb_ff   <= txb_in;
         rirq_ff  <= rirq_in;
         tirq_ff  <= tirq_in;
         space_ff <= space_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= '0;
         end
         rf_ff[R_TRSTAT] <= TRSTAT_RESET;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         rx_on_ff   <= 1'b0;
         tx_on_ff   <= 1'b0;
         fifo_on_ff <= 1'b0;
         link_ff    <= 1'b1;
      end else begin
         if (cmd.execute) begin
            rf_ff      <= rf_in;
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            count_ff   <= count_in;
            rx_on_ff   <= rx_on_in;
            tx_on_ff   <= tx_on_in;
            fifo_on_ff <= fifo_on_in;
         end
         if (csr_write) begin
            link_ff <= csr_data;
         end
      end
   end

   assign rsp_read_data = rd_ff;
   assign rsp_tx_valid  = txv_ff;
   assign rsp_tx_byte   = txb_ff;
   assign rsp_rx_irq    = rirq_ff;
   assign rsp_tx_irq    = tirq_ff;
   assign rsp_rx_space  = space_ff;

endmodule

@@ tb/uart_register_file_rx_fifo_core_test.sv @@
`timescale 1ns / 100ps

// Testbench for the UART register file with its receive FIFO.
//
// A short scripted sequence comes first. It covers reset values, unmapped
// register indexes, the unused command, a byte that arrives with receive
// switched off, transmit writes, read-to-clear of the error register, FIFO
// pushes and pops, a pop of an empty FIFO, and a write to the FIFO status
// register. Random phases follow, alternating the link_present setting.
// Most of their words are well-formed bursts: the receiver is enabled,
// bytes are pushed until the FIFO fills and overflows, and the FIFO is
// drained until it runs empty. Noise words and random register writes
// are mixed in.
//
// Every accepted request word runs through a predictor that keeps its own
// image of the registers and the FIFO. The predicted response word goes
// into a queue, and each response word that the block delivers is compared
// field by field with the oldest entry in that queue.
module uart_register_file_rx_fifo_core_test;
   import uartrf_pkg::*;

   localparam int FIFO_DEPTH = DEF_FIFO_DEPTH;

   // Command 3 is not decoded by the block, and indexes 12 to 15 are unmapped.
   localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
   localparam logic [IDX_W-1:0] IDX_UNMAPPED   = 4'd12;
   localparam logic [IDX_W-1:0] IDX_TOP        = 4'd15;
   localparam logic [3:0]       CON_RX_TX_ON   = 4'b0101;
   localparam int               IDLE_PERCENT   = 25;
   localparam int               PHASE_WORDS    = 80;
   localparam int               REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [IDX_W-1:0]  register_index;
      logic [DATA_W-1:0] write_data;
      logic [BYTE_W-1:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               tx_valid;
      logic [BYTE_W-1:0]  tx_byte;
      logic               rx_irq;
      logic               tx_irq;
      logic [SPACE_W-1:0] rx_space;
   } rsp_word_type;

   // One line of the scripted sequence. When typed is set, want holds the
   // response word written out by hand; otherwise the predictor decides.
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } script_row_type;

   logic clock;
   logic reset;

   uartrf_req_if req_ch ();
   uartrf_rsp_if rsp_ch ();
   uartrf_csr_if csr_ch ();

   uart_register_file_rx_fifo_core #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Predictor state: the register image, the receive FIFO and the enables.
   logic [DATA_W-1:0] reg_image [REG_COUNT];
   logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];
   int                rx_rd_ptr;
   int                rx_wr_ptr;
   logic [SPACE_W-1:0] rx_fill;
   logic              recv_en;
   logic              xmit_en;
   logic              fifo_en;
   logic              link_up;

   rsp_word_type   pending_rsp [$];
   script_row_type script [$];
   int             fault_count;

   // Hand-typed expectation for the word now on the request channel.
   logic         typed_now;
   rsp_word_type typed_rsp;

   // When set, neither side inserts idle cycles.
   logic steady;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Computes the response word for one request word and advances the
   // predictor state, exactly as the block is meant to.
   function automatic rsp_word_type uart_predict(input req_word_type w);
      rsp_word_type r;
      logic [DATA_W-1:0] wd;
      r  = '0;
      wd = w.write_data;
      if (w.command == CMD_READ && w.register_index < REG_COUNT) begin
         if (w.register_index == R_ERSTAT) begin
            // The error register clears itself when read.
            r.read_data = reg_image[R_ERSTAT];
            reg_image[R_ERSTAT] = '0;
         end else if (w.register_index == R_RXH) begin
            if (!fifo_en) begin
               reg_image[R_TRSTAT] = reg_image[R_TRSTAT] & ~ST_RX_READY;
               r.read_data = reg_image[R_RXH];
            end else if (rx_fill != 0) begin
               // A pop; an empty FIFO returns zero and changes nothing.
               r.read_data = {{(DATA_W-BYTE_W){1'b0}}, rx_mem[rx_rd_ptr]};
               rx_rd_ptr = (rx_rd_ptr == FIFO_DEPTH - 1) ? 0 : rx_rd_ptr + 1;
               rx_fill = rx_fill - 1'b1;
               if (rx_fill == 0)
                  reg_image[R_TRSTAT] = reg_image[R_TRSTAT] & ~ST_RX_READY;
               else
                  reg_image[R_TRSTAT] = reg_image[R_TRSTAT] | ST_RX_READY;
               reg_image[R_FSTAT] = reg_image[R_FSTAT] & ~FS_FULL_BIT;
               reg_image[R_FSTAT][FS_COUNT_W-1:0] = rx_fill[FS_COUNT_W-1:0];
            end
         end else begin
            r.read_data = reg_image[w.register_index];
         end
      end else if (w.command == CMD_WRITE && w.register_index < REG_COUNT) begin
         if (w.register_index == R_CON) begin
            reg_image[R_CON] = wd;
            recv_en = (wd[1:0] == CON_MODE_ON);
            xmit_en = (wd[3:2] == CON_MODE_ON);
            r.tx_irq = xmit_en;
         end else if (w.register_index == R_FCON) begin
            reg_image[R_FCON] = wd;
            fifo_en = wd[0];
         end else if (w.register_index == R_TXH) begin
            // The transmit register is never stored; the byte goes out only
            // when a back end is attached.
            if (link_up) begin
               reg_image[R_TRSTAT] = reg_image[R_TRSTAT] | ST_TX_EMPTY;
               r.tx_valid = 1'b1;
               r.tx_byte  = wd[BYTE_W-1:0];
               r.tx_irq   = xmit_en;
            end
         end else begin
            reg_image[w.register_index] = wd;
         end
      end else if (w.command == CMD_RECV && recv_en) begin
         if (fifo_en) begin
            // A byte that meets a full FIFO is dropped without a trace.
            if (rx_fill < FIFO_DEPTH) begin
               rx_mem[rx_wr_ptr] = w.rx_byte;
               rx_wr_ptr = (rx_wr_ptr == FIFO_DEPTH - 1) ? 0 : rx_wr_ptr + 1;
               rx_fill = rx_fill + 1'b1;
               r.rx_irq = 1'b1;
               if (rx_fill == FIFO_DEPTH)
                  reg_image[R_FSTAT] = reg_image[R_FSTAT] | FS_FULL_BIT;
               reg_image[R_FSTAT][FS_COUNT_W-1:0] = rx_fill[FS_COUNT_W-1:0];
               reg_image[R_TRSTAT] = reg_image[R_TRSTAT] | ST_RX_READY;
            end
         end else begin
            reg_image[R_RXH] = {{(DATA_W-BYTE_W){1'b0}}, w.rx_byte};
            r.rx_irq = 1'b1;
            reg_image[R_TRSTAT] = reg_image[R_TRSTAT] | ST_RX_READY;
         end
      end
      r.rx_space = fifo_en ? SPACE_W'(FIFO_DEPTH - rx_fill) : SPACE_W'(1);
      return r;
   endfunction

   // The scoreboard samples both channels at each rising edge. Responses are
   // handled before requests, although a response can never belong to a
   // word accepted at the same edge.
   always @(posedge clock) begin : scoreboard
      req_word_type taken;
      rsp_word_type seen;
      rsp_word_type want;
      if (reset) begin
         foreach (reg_image[i]) reg_image[i] = '0;
         reg_image[R_TRSTAT] = TRSTAT_RESET;
         rx_rd_ptr = 0;
         rx_wr_ptr = 0;
         rx_fill   = '0;
         recv_en   = 1'b0;
         xmit_en   = 1'b0;
         fifo_en   = 1'b0;
         link_up   = 1'b1;
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            link_up = csr_ch.data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.read_data, rsp_ch.tx_valid, rsp_ch.tx_byte,
                    rsp_ch.rx_irq, rsp_ch.tx_irq, rsp_ch.rx_space};
            if (pending_rsp.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: response word with nothing expected", $realtime);
            end else begin
               want = pending_rsp.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch (expected/actual) read_data %h/%h tx_valid %b/%b",
                              $realtime, want.read_data, seen.read_data,
                              want.tx_valid, seen.tx_valid);
                     $display("   tx_byte %h/%h rx_irq %b/%b tx_irq %b/%b rx_space %0d/%0d",
                              want.tx_byte, seen.tx_byte, want.rx_irq, seen.rx_irq,
                              want.tx_irq, seen.tx_irq, want.rx_space, seen.rx_space);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken = {req_ch.command, req_ch.register_index, req_ch.write_data,
                     req_ch.rx_byte};
            want = uart_predict(taken);
            if (typed_now)
               want = typed_rsp;
            pending_rsp.push_back(want);
         end
      end
   end

   // The response side stalls about a quarter of the time unless steady.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_word_type mk_word(input logic [CMD_W-1:0] cmd,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] wd,
                                            input logic [BYTE_W-1:0] rb);
      return {cmd, idx, wd, rb};
   endfunction

   function automatic rsp_word_type mk_rsp(input logic [DATA_W-1:0] rd,
                                           input logic txv,
                                           input logic [BYTE_W-1:0] txb,
                                           input logic rirq,
                                           input logic tirq,
                                           input logic [SPACE_W-1:0] space);
      return {rd, txv, txb, rirq, tirq, space};
   endfunction

   function automatic void add_row(input req_word_type w, input logic typed,
                                   input rsp_word_type want);
      script.push_back({w, typed, want});
   endfunction

   // Presents one request word, after a random number of idle cycles, and
   // returns at the edge where it is accepted. Valid stays high on return so
   // that back-to-back words need no second assignment in one step.
   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type want);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.command        <= w.command;
      req_ch.register_index <= w.register_index;
      req_ch.write_data     <= w.write_data;
      req_ch.rx_byte        <= w.rx_byte;
      typed_now             <= typed;
      typed_rsp             <= want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_plain(input req_word_type w);
      send_word(w, 1'b0, '0);
   endtask

   // Lets the block go quiet: no request on offer and every response in.
   // The first edge lets the scoreboard record the word accepted last.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_link(input logic value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int made;
      int burst;
      logic [DATA_W-1:0] wd;
      logic [IDX_W-1:0]  idx;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.command        <= CMD_READ;
      req_ch.register_index <= '0;
      req_ch.write_data     <= '0;
      req_ch.rx_byte        <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.data           <= 1'b0;
      typed_now             <= 1'b0;
      typed_rsp             <= '0;
      steady                <= 1'b0;
      fault_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_link(1'b1);

      // Scripted words, from the reset state with receive, transmit and the
      // FIFO all switched off and a transmit back end attached.
      add_row(mk_word(CMD_READ, R_TRSTAT, '0, '0), 1'b1,
              mk_rsp(TRSTAT_RESET, 1'b0, '0, 1'b0, 1'b0, 7'd1));
      add_row(mk_word(CMD_READ, IDX_TOP, '1, '1), 1'b1, mk_rsp('0, 1'b0, '0, 1'b0, 1'b0, 7'd1));
      add_row(mk_word(CMD_WRITE, IDX_UNMAPPED, '1, '1), 1'b1,
              mk_rsp('0, 1'b0, '0, 1'b0, 1'b0, 7'd1));
      add_row(mk_word(CMD_UNUSED, R_TRSTAT, '1, '1), 1'b1,
              mk_rsp('0, 1'b0, '0, 1'b0, 1'b0, 7'd1));
      // A byte from the line while receive is off is ignored.
      add_row(mk_word(CMD_RECV, R_RXH, '0, 8'hff), 1'b1, mk_rsp('0, 1'b0, '0, 1'b0, 1'b0, 7'd1));
      add_row(mk_word(CMD_WRITE, R_TXH, 32'h0000_00a5, '0), 1'b1,
              mk_rsp('0, 1'b1, 8'ha5, 1'b0, 1'b0, 7'd1));
      add_row(mk_word(CMD_WRITE, R_CON, 32'h0000_0005, '0), 1'b1,
              mk_rsp('0, 1'b0, '0, 1'b0, 1'b1, 7'd1));
      add_row(mk_word(CMD_WRITE, R_TXH, '1, '0), 1'b1, mk_rsp('0, 1'b1, 8'hff, 1'b0, 1'b1, 7'd1));
      // Without the FIFO each byte overwrites the receive buffer.
      add_row(mk_word(CMD_RECV, R_CON, '0, 8'h00), 1'b0, '0);
      add_row(mk_word(CMD_RECV, R_CON, '0, 8'hff), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_RXH, '0, '0), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_TRSTAT, '0, '0), 1'b0, '0);
      // The error register reads back once and then reads as zero.
      add_row(mk_word(CMD_WRITE, R_ERSTAT, '1, '0), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_ERSTAT, '0, '0), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_ERSTAT, '0, '0), 1'b0, '0);
      add_row(mk_word(CMD_WRITE, R_FCON, 32'h0000_0001, '0), 1'b1,
              mk_rsp('0, 1'b0, '0, 1'b0, 1'b0, 7'd64));
      add_row(mk_word(CMD_RECV, R_RXH, '0, 8'h80), 1'b0, '0);
      add_row(mk_word(CMD_RECV, R_RXH, '0, 8'h7f), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_FSTAT, '0, '0), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_RXH, '0, '0), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_RXH, '0, '0), 1'b0, '0);
      // Popping an empty FIFO returns zero.
      add_row(mk_word(CMD_READ, R_RXH, '0, '0), 1'b1, mk_rsp('0, 1'b0, '0, 1'b0, 1'b0, 7'd64));
      // A bus write to the FIFO status register leaves the fill level alone.
      add_row(mk_word(CMD_WRITE, R_FSTAT, '1, '0), 1'b0, '0);
      add_row(mk_word(CMD_READ, R_FSTAT, '0, '0), 1'b0, '0);
      add_row(mk_word(CMD_WRITE, R_CON, '0, '0), 1'b0, '0);
      foreach (script[i])
         send_word(script[i].word, script[i].typed, script[i].want);

      // Random phases, alternating the link setting between its two values.
      // The second phase runs with no idle cycles on either side.
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         write_link(phase[0]);
         steady <= (phase == 1);
         wd = $urandom;
         wd[3:0] = CON_RX_TX_ON;
         send_plain(mk_word(CMD_WRITE, R_CON, wd, '0));
         wd = $urandom;
         wd[0] = 1'b1;
         send_plain(mk_word(CMD_WRITE, R_FCON, wd, '0));
         made = 0;
         while (made < PHASE_WORDS) begin
            // Long bursts are what fill the FIFO to overflow or drain it dry.
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 72)
                                                : $urandom_range(1, 16);
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  for (int k = 0; k < burst; k++)
                     send_plain(mk_word(CMD_RECV, IDX_W'($urandom_range(0, 15)),
                                        $urandom, BYTE_W'($urandom)));
                  made += burst;
               end
               3, 4: begin
                  for (int k = 0; k < burst; k++)
                     send_plain(mk_word(CMD_READ, R_RXH, $urandom, BYTE_W'($urandom)));
                  made += burst;
               end
               5: begin
                  wd = $urandom;
                  if ($urandom_range(0, 3) != 0)
                     wd[3:0] = CON_RX_TX_ON;
                  send_plain(mk_word(CMD_WRITE, R_CON, wd, BYTE_W'($urandom)));
                  made++;
               end
               6: begin
                  wd = $urandom;
                  if ($urandom_range(0, 3) != 0)
                     wd[0] = 1'b1;
                  send_plain(mk_word(CMD_WRITE, R_FCON, wd, BYTE_W'($urandom)));
                  made++;
               end
               7: begin
                  idx = ($urandom_range(0, 1) == 0) ? R_TXH : IDX_W'($urandom_range(0, 15));
                  send_plain(mk_word(CMD_WRITE, idx, $urandom, BYTE_W'($urandom)));
                  made++;
               end
               8: begin
                  send_plain(mk_word(CMD_READ, IDX_W'($urandom_range(0, 15)), $urandom,
                                     BYTE_W'($urandom)));
                  made++;
               end
               default: begin
                  // Noise: any command, including the unused one, with any
                  // index. These words do not count toward the phase.
                  send_plain(mk_word(CMD_W'($urandom_range(0, 3)),
                                     IDX_W'($urandom_range(0, 15)), $urandom,
                                     BYTE_W'($urandom)));
               end
            endcase
         end
      end
      settle();

      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
